/* hw/rtl/klx_pkg.sv */
`timescale 1ns / 1ps

package klx_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 8;
   localparam int KW_CHARS    = 6;
   localparam int PREFIX_W    = 8 * KW_CHARS;
   localparam int NUM_KW      = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // character classes
   localparam logic [3:0] CLS_SPACE   = 4'd0;
   localparam logic [3:0] CLS_LETTER  = 4'd1;
   localparam logic [3:0] CLS_DIGIT   = 4'd2;
   localparam logic [3:0] CLS_PLUS    = 4'd3;
   localparam logic [3:0] CLS_MINUS   = 4'd4;
   localparam logic [3:0] CLS_STAR    = 4'd5;
   localparam logic [3:0] CLS_SEMI    = 4'd6;
   localparam logic [3:0] CLS_LT      = 4'd7;
   localparam logic [3:0] CLS_EQ      = 4'd8;
   localparam logic [3:0] CLS_ILLEGAL = 4'd9;

   // token type codes
   localparam logic [3:0] CODE_LT     = 4'd0;
   localparam logic [3:0] CODE_NONE   = 4'd0;
   localparam logic [3:0] CODE_IDENT  = 4'd6;
   localparam logic [3:0] CODE_NUMBER = 4'd7;
   localparam logic [3:0] CODE_ASSIGN = 4'd7;
   localparam logic [3:0] CODE_SEMI   = 4'd8;
   localparam logic [3:0] CODE_LE     = 4'd9;
   localparam logic [3:0] CODE_EQEQ   = 4'd10;
   localparam logic [3:0] CODE_PLUS   = 4'd11;
   localparam logic [3:0] CODE_MINUS  = 4'd12;
   localparam logic [3:0] CODE_STAR   = 4'd13;

   // token kinds
   localparam logic [1:0] KIND_OP      = 2'd0;
   localparam logic [1:0] KIND_IDENT   = 2'd1;
   localparam logic [1:0] KIND_NUMBER  = 2'd2;
   localparam logic [1:0] KIND_ILLEGAL = 2'd3;

   // keyword text, first character in the low byte
   localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
      48'h0065_6c69_6877,
      48'h0000_0000_6669,
      48'h0000_6573_6c65,
      48'h6863_7469_7773,
      48'h0000_6573_6163,
      48'h0070_6f6c_6572
   };
   localparam logic [LENGTH_BITS-1:0] KW_LEN [NUM_KW] = '{
      LENGTH_BITS'(5), LENGTH_BITS'(2), LENGTH_BITS'(4),
      LENGTH_BITS'(6), LENGTH_BITS'(4), LENGTH_BITS'(5)
   };

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]             token_code;
      logic [1:0]             token_kind;
      logic [COUNT_BITS-1:0]  token_index;
      logic [LENGTH_BITS-1:0] token_length;
      logic [7:0]             bad_char;
      logic                   last;
   } rsp_type;

   // classified character handed from front to back
   typedef struct packed {
      logic       end_of_input;
      logic [7:0] char_in;
      logic [3:0] char_class;
   } cmd_type;

   // keyword code 1..6, or CODE_NONE when the word is no keyword
   function automatic logic [3:0] kw_lookup(input logic [PREFIX_W-1:0]    prefix,
                                            input logic [LENGTH_BITS-1:0] len);
      logic [3:0] code;
      code = CODE_NONE;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
            code = 4'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

/* hw/rtl/klx_front.sv */
`timescale 1ns / 1ps

module klx_front import klx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push,
   output cmd_type push_cmd
);

   function automatic logic [3:0] classify(input logic [7:0] c);
      logic [3:0] cls;
      cls = CLS_ILLEGAL;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0a) begin
         cls = CLS_SPACE;
      end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) begin
         cls = CLS_LETTER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         cls = CLS_DIGIT;
      end else begin
         case (c)
            8'h2b:   cls = CLS_PLUS;
            8'h2d:   cls = CLS_MINUS;
            8'h2a:   cls = CLS_STAR;
            8'h3b:   cls = CLS_SEMI;
            8'h3c:   cls = CLS_LT;
            8'h3d:   cls = CLS_EQ;
            default: cls = CLS_ILLEGAL;
         endcase
      end
      return cls;
   endfunction

   logic seen_ff;
   logic seen_in;

   // tracks whether anything came in since reset, keeps stall low in reset
   assign seen_in = reset ? 1'b0 : (seen_ff | push);

   always_ff @(posedge clock) begin
      seen_ff <= seen_in;
   end

   assign req_stall = queue_full & (seen_ff | ~reset);
   assign push      = req_valid & ~queue_full;

   always_comb begin
      push_cmd.end_of_input = req_data.end_of_input;
      push_cmd.char_in      = req_data.char_in;
      push_cmd.char_class   = classify(req_data.char_in);
   end

endmodule

/* hw/rtl/klx_queue.sv */
`timescale 1ns / 1ps

module klx_queue import klx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!push && do_pop) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/klx_back.sv */
`timescale 1ns / 1ps

module klx_back import klx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_LT     = 3'd3;
   localparam logic [2:0] MODE_EQ     = 3'd4;
   localparam logic [2:0] MODE_HALT   = 3'd5;

   logic [2:0]             mode_ff, mode_in;
   logic [PREFIX_W-1:0]    prefix_ff, prefix_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [COUNT_BITS-1:0]  idc_ff, idc_in;
   logic [COUNT_BITS-1:0]  nmc_ff, nmc_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_type                pend_ff, pend_in;

   logic                   first_valid, idle_valid;
   rsp_type                first_res, idle_res;
   logic                   out_free;
   logic [3:0]             kw_code;

   function automatic rsp_type mk(input logic [3:0]             code,
                                  input logic [1:0]             kind,
                                  input logic [COUNT_BITS-1:0]  index,
                                  input logic [LENGTH_BITS-1:0] len,
                                  input logic [7:0]             bad);
      rsp_type r;
      r.token_code   = code;
      r.token_kind   = kind;
      r.token_index  = index;
      r.token_length = len;
      r.bad_char     = bad;
      r.last         = 1'b0;
      return r;
   endfunction

   assign kw_code = kw_lookup(prefix_ff, len_ff);

   // lexer step on the head item
   always_comb begin
      logic consumed;
      logic do_flush;
      logic add;
      consumed    = 1'b0;
      do_flush    = 1'b0;
      add         = 1'b0;
      mode_in     = mode_ff;
      prefix_in   = prefix_ff;
      len_in      = len_ff;
      idc_in      = idc_ff;
      nmc_in      = nmc_ff;
      first_valid = 1'b0;
      first_res   = mk(CODE_NONE, KIND_OP, '0, '0, 8'h00);
      idle_valid  = 1'b0;
      idle_res    = mk(CODE_NONE, KIND_OP, '0, '0, 8'h00);
      if (mode_ff != MODE_HALT) begin
         if (head_cmd.end_of_input) begin
            do_flush = 1'b1;
         end else begin
            case (mode_ff)
               MODE_IDENT: begin
                  if (head_cmd.char_class == CLS_LETTER || head_cmd.char_class == CLS_DIGIT) begin
                     add      = 1'b1;
                     consumed = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (head_cmd.char_class == CLS_DIGIT) begin
                     add      = 1'b1;
                     consumed = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_LT: begin
                  if (head_cmd.char_class == CLS_EQ) begin
                     first_valid = 1'b1;
                     first_res   = mk(CODE_LE, KIND_OP, '0, LENGTH_BITS'(2), 8'h00);
                     mode_in     = MODE_IDLE;
                     consumed    = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_EQ: begin
                  if (head_cmd.char_class == CLS_EQ) begin
                     first_valid = 1'b1;
                     first_res   = mk(CODE_EQEQ, KIND_OP, '0, LENGTH_BITS'(2), 8'h00);
                     mode_in     = MODE_IDLE;
                     consumed    = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end

         // pending token ends here
         if (do_flush) begin
            case (mode_ff)
               MODE_IDENT: begin
                  first_valid = 1'b1;
                  if (kw_code != CODE_NONE) begin
                     first_res = mk(kw_code, KIND_OP, '0, len_ff, 8'h00);
                  end else begin
                     first_res = mk(CODE_IDENT, KIND_IDENT, idc_ff, len_ff, 8'h00);
                     if (idc_ff != '1) begin
                        idc_in = COUNT_BITS'(idc_ff + 1'b1);
                     end
                  end
               end
               MODE_NUMBER: begin
                  first_valid = 1'b1;
                  first_res   = mk(CODE_NUMBER, KIND_NUMBER, nmc_ff, len_ff, 8'h00);
                  if (nmc_ff != '1) begin
                     nmc_in = COUNT_BITS'(nmc_ff + 1'b1);
                  end
               end
               MODE_LT: begin
                  first_valid = 1'b1;
                  first_res   = mk(CODE_LT, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               MODE_EQ: begin
                  first_valid = 1'b1;
                  first_res   = mk(CODE_ASSIGN, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               default: begin
                  first_valid = 1'b0;
               end
            endcase
            mode_in = MODE_IDLE;
         end

         // keep the first six characters of a word
         if (add) begin
            for (int i = 0; i < KW_CHARS; i++) begin
               if (len_ff == LENGTH_BITS'(i)) begin
                  prefix_in[8*i +: 8] = head_cmd.char_in;
               end
            end
            if (len_ff != '1) begin
               len_in = LENGTH_BITS'(len_ff + 1'b1);
            end
         end

         // ending character, or a character seen from idle
         if (!head_cmd.end_of_input && !consumed) begin
            case (head_cmd.char_class)
               CLS_SPACE: begin
                  mode_in = MODE_IDLE;
               end
               CLS_LETTER: begin
                  prefix_in = {{(PREFIX_W-8){1'b0}}, head_cmd.char_in};
                  len_in    = LENGTH_BITS'(1);
                  mode_in   = MODE_IDENT;
               end
               CLS_DIGIT: begin
                  prefix_in = {{(PREFIX_W-8){1'b0}}, head_cmd.char_in};
                  len_in    = LENGTH_BITS'(1);
                  mode_in   = MODE_NUMBER;
               end
               CLS_PLUS: begin
                  idle_valid = 1'b1;
                  idle_res   = mk(CODE_PLUS, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               CLS_MINUS: begin
                  idle_valid = 1'b1;
                  idle_res   = mk(CODE_MINUS, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               CLS_STAR: begin
                  idle_valid = 1'b1;
                  idle_res   = mk(CODE_STAR, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               CLS_SEMI: begin
                  idle_valid = 1'b1;
                  idle_res   = mk(CODE_SEMI, KIND_OP, '0, LENGTH_BITS'(1), 8'h00);
               end
               CLS_LT: begin
                  mode_in = MODE_LT;
               end
               CLS_EQ: begin
                  mode_in = MODE_EQ;
               end
               default: begin
                  idle_valid = 1'b1;
                  idle_res   = mk(CODE_NONE, KIND_ILLEGAL, '0, LENGTH_BITS'(1),
                                  head_cmd.char_in);
                  mode_in    = MODE_HALT;
               end
            endcase
         end
      end
      first_res.last = ~idle_valid;
      idle_res.last  = 1'b1;
   end

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign pop      = head_valid & ~pend_valid_ff &
                     (out_free | ~(first_valid | idle_valid));

   // output register plus one slot for the second result of an item
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (pop && (first_valid || idle_valid)) begin
            out_valid_in = 1'b1;
            out_in       = first_valid ? first_res : idle_res;
            if (first_valid && idle_valid) begin
               pend_in       = idle_res;
               pend_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         prefix_ff     <= '0;
         len_ff        <= '0;
         idc_ff        <= '0;
         nmc_ff        <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff   <= mode_in;
            prefix_ff <= prefix_in;
            len_ff    <= len_in;
            idc_ff    <= idc_in;
            nmc_ff    <= nmc_in;
         end
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* hw/rtl/keyword_token_lexer.sv */
`timescale 1ns / 1ps

// keyword token lexer: one character byte per input item, tokens out
// req channel: req_data carries char_in and end_of_input; an item is taken
//   at a clock edge with req_valid high and req_stall low
// rsp channel: rsp_data carries one token per item, rsp_valid / rsp_stall;
//   last marks the final token caused by one input item
// the front classifies each character and writes it into a four-entry
//   queue; the back runs the token state machine on the queue head
// throughput: one character per cycle while the receiver does not stall;
//   a character that both ends a token and forms a token itself yields
//   two tokens and holds the back while the second one goes out
// the character that ends a token is first written into the queue; the
//   token is then formed at the queue head and loaded into the output register
// a stalled receiver holds the output register; the back stops at the
//   queue head and req_stall rises once the queue is full
// reset (synchronous) empties the queue, clears the counts and the word
//   state and releases the halt after an illegal character
module keyword_token_lexer import klx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // character classification and input handshake
   klx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decouples input acceptance from token output
   klx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // token state machine, counts and output registers
   klx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/sv/lexer_token_checker.sv */
`timescale 1ns / 1ps

module lexer_token_checker import klx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      tokens_outstanding
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_NUMBER,
      SCAN_LESS,
      SCAN_EQUAL,
      SCAN_HALTED
   } scan_mode_type;

   scan_mode_type          scan_mode;
   logic [PREFIX_W-1:0]    word_prefix;
   logic [LENGTH_BITS-1:0] word_len;
   logic [COUNT_BITS-1:0]  ident_total;
   logic [COUNT_BITS-1:0]  number_total;
   rsp_type                tokens_due [$];
   rsp_type                step_tokens [$];
   string                  keyword_words [NUM_KW];
   int                     errors = 0;

   initial begin
      keyword_words[0] = "while";
      keyword_words[1] = "if";
      keyword_words[2] = "else";
      keyword_words[3] = "switch";
      keyword_words[4] = "case";
      keyword_words[5] = "relop";
   end

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // first character in the low byte
   function automatic logic [PREFIX_W-1:0] pack_text(input string s);
      logic [PREFIX_W-1:0] text;
      text = '0;
      for (int i = 0; i < s.len() && i < KW_CHARS; i++) begin
         text[8*i +: 8] = s[i];
      end
      return text;
   endfunction

   function automatic logic [3:0] keyword_code(input logic [PREFIX_W-1:0]    text,
                                               input logic [LENGTH_BITS-1:0] len);
      for (int k = 0; k < NUM_KW; k++) begin
         if (len == keyword_words[k].len() && text == pack_text(keyword_words[k])) begin
            return 4'(k + 1);
         end
      end
      return CODE_NONE;
   endfunction

   task automatic emit_token(input logic [3:0]             code,
                             input logic [1:0]             kind,
                             input logic [COUNT_BITS-1:0]  index,
                             input logic [LENGTH_BITS-1:0] len,
                             input logic [7:0]             bad);
      rsp_type tok;
      tok.token_code   = code;
      tok.token_kind   = kind;
      tok.token_index  = index;
      tok.token_length = len;
      tok.bad_char     = bad;
      tok.last         = 1'b0;
      step_tokens.insert(step_tokens.size(), tok);
   endtask

   task automatic start_word(input logic [7:0] c, input scan_mode_type next_mode);
      word_prefix = '0;
      word_prefix[7:0] = c;
      word_len = LENGTH_BITS'(1);
      scan_mode = next_mode;
   endtask

   task automatic grow_word(input logic [7:0] c);
      if (word_len < KW_CHARS) word_prefix[8*word_len +: 8] = c;
      if (word_len != '1) word_len++;
   endtask

   task automatic close_token();
      logic [3:0] code;
      case (scan_mode)
         SCAN_WORD: begin
            code = CODE_NONE;
            if (word_len <= KW_CHARS) code = keyword_code(word_prefix, word_len);
            if (code != CODE_NONE) begin
               emit_token(code, KIND_OP, '0, word_len, '0);
            end else begin
               emit_token(CODE_IDENT, KIND_IDENT, ident_total, word_len, '0);
               if (ident_total != '1) ident_total++;
            end
         end
         SCAN_NUMBER: begin
            emit_token(CODE_NUMBER, KIND_NUMBER, number_total, word_len, '0);
            if (number_total != '1) number_total++;
         end
         SCAN_LESS:  emit_token(CODE_LT, KIND_OP, '0, LENGTH_BITS'(1), '0);
         SCAN_EQUAL: emit_token(CODE_ASSIGN, KIND_OP, '0, LENGTH_BITS'(1), '0);
         default: ;
      endcase
      scan_mode = SCAN_IDLE;
   endtask

   task automatic scan_fresh(input logic [7:0] c);
      if (c == " " || c == "\t" || c == "\n") return;
      if (is_letter(c)) begin
         start_word(c, SCAN_WORD);
         return;
      end
      if (is_digit(c)) begin
         start_word(c, SCAN_NUMBER);
         return;
      end
      case (c)
         "+": emit_token(CODE_PLUS, KIND_OP, '0, LENGTH_BITS'(1), '0);
         "-": emit_token(CODE_MINUS, KIND_OP, '0, LENGTH_BITS'(1), '0);
         "*": emit_token(CODE_STAR, KIND_OP, '0, LENGTH_BITS'(1), '0);
         ";": emit_token(CODE_SEMI, KIND_OP, '0, LENGTH_BITS'(1), '0);
         "<": scan_mode = SCAN_LESS;
         "=": scan_mode = SCAN_EQUAL;
         default: begin
            emit_token(CODE_NONE, KIND_ILLEGAL, '0, LENGTH_BITS'(1), c);
            scan_mode = SCAN_HALTED;
         end
      endcase
   endtask

   // tokens caused by one accepted character, queued in order
   task automatic lex_char(input req_type item);
      logic [7:0] c;
      logic       consumed;
      rsp_type    tail;
      c = item.char_in;
      consumed = 1'b0;
      step_tokens.delete();
      if (scan_mode == SCAN_HALTED) return;
      if (item.end_of_input) begin
         close_token();
      end else begin
         case (scan_mode)
            SCAN_WORD: begin
               if (is_letter(c) || is_digit(c)) begin
                  grow_word(c);
                  consumed = 1'b1;
               end else close_token();
            end
            SCAN_NUMBER: begin
               if (is_digit(c)) begin
                  grow_word(c);
                  consumed = 1'b1;
               end else close_token();
            end
            SCAN_LESS: begin
               if (c == "=") begin
                  emit_token(CODE_LE, KIND_OP, '0, LENGTH_BITS'(2), '0);
                  scan_mode = SCAN_IDLE;
                  consumed = 1'b1;
               end else close_token();
            end
            SCAN_EQUAL: begin
               if (c == "=") begin
                  emit_token(CODE_EQEQ, KIND_OP, '0, LENGTH_BITS'(2), '0);
                  scan_mode = SCAN_IDLE;
                  consumed = 1'b1;
               end else close_token();
            end
            default: scan_mode = SCAN_IDLE;
         endcase
         // the character that ended a token starts over from idle
         if (!consumed) scan_fresh(c);
      end
      if (step_tokens.size() > 0) begin
         tail = step_tokens[step_tokens.size() - 1];
         tail.last = 1'b1;
         step_tokens[step_tokens.size() - 1] = tail;
      end
      foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
   endtask

   task automatic check_token(input rsp_type got);
      rsp_type want;
      if (tokens_due.size() == 0) begin
         $error("unexpected token: code %0d kind %0d index %0d length %0d",
                got.token_code, got.token_kind, got.token_index, got.token_length);
         errors++;
         return;
      end
      want = tokens_due.pop_front();
      if (got.token_code !== want.token_code) begin
         $error("token_code: expected %0d, got %0d", want.token_code, got.token_code);
         errors++;
      end
      if (got.token_kind !== want.token_kind) begin
         $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
         errors++;
      end
      if (got.token_index !== want.token_index) begin
         $error("token_index: expected %0d, got %0d", want.token_index, got.token_index);
         errors++;
      end
      if (got.token_length !== want.token_length) begin
         $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
         errors++;
      end
      if (got.bad_char !== want.bad_char) begin
         $error("bad_char: expected %0h, got %0h", want.bad_char, got.bad_char);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_mode = SCAN_IDLE;
         word_prefix = '0;
         word_len = '0;
         ident_total = '0;
         number_total = '0;
         tokens_due.delete();
      end else begin
         if (req_valid && !req_stall) lex_char(req_data);
         if (rsp_valid && !rsp_stall) check_token(rsp_data);
      end
      mismatch_count <= errors;
      tokens_outstanding <= tokens_due.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   import klx_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int HALT_TAIL    = 40;    // characters sent after the halt, all ignored
   localparam int DRAIN_CYCLES = 20;    // well past the token latency
   localparam int MAX_LONG     = 3;     // words long enough to saturate the length

   // receiver stall patterns, each held for a random segment of cycles
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatch_count;
   int tokens_outstanding;

   // sender bookkeeping
   int chars_sent = 0;
   int burst_left = 0;
   int long_words = 0;
   int next_pause = 0;

   // receiver pattern state
   stall_style_type stall_style = STALL_NONE;
   int stall_segment = 0;
   int stall_period  = 2;
   int stall_on      = 1;
   int stall_phase   = 0;

   keyword_token_lexer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // watches both channels, predicts every token and compares
   lexer_token_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .mismatch_count     (mismatch_count),
      .tokens_outstanding (tokens_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[keyword_token_lexer] ERROR");
      $finish;
   end

   // receiver: pick a stall pattern per segment, from never to most of the time
   always @(posedge clock) begin
      if (stall_segment == 0) begin
         stall_segment = $urandom_range(40, 300);
         stall_style   = stall_style_type'($urandom_range(0, 3));
         stall_period  = $urandom_range(2, 8);
         stall_on      = $urandom_range(1, stall_period - 1);
      end
      stall_segment--;
      stall_phase = (stall_phase + 1) % stall_period;
      case (stall_style)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase < stall_on);
         default:        rsp_stall <= ($urandom_range(0, 1) == 1);
      endcase
   end

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return "0" + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_space();
      case ($urandom_range(0, 2))
         0:       return " ";
         1:       return "\t";
         default: return "\n";
      endcase
   endfunction

   function automatic string random_keyword();
      case ($urandom_range(0, 5))
         0:       return "while";
         1:       return "if";
         2:       return "else";
         3:       return "switch";
         4:       return "case";
         default: return "relop";
      endcase
   endfunction

   // anything outside the lexer's alphabet halts it
   function automatic logic is_legal(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
         || c == " " || c == "\t" || c == "\n" || c == "+" || c == "-" || c == "*"
         || c == ";" || c == "<" || c == "=";
   endfunction

   // carriage return now and then, else any other illegal byte
   function automatic logic [7:0] illegal_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) return 8'h0D;
      do c = 8'($urandom_range(0, 255)); while (is_legal(c));
      return c;
   endfunction

   // one item on the request channel; bursts of random length, random gaps
   task automatic send_char(input logic [7:0] ch, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{char_in: ch, end_of_input: eoi};
      do @(posedge clock); while (req_stall);
      burst_left--;
      chars_sent++;
   endtask

   task automatic send_eoi();
      // the character byte rides along but is ignored
      send_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   task automatic send_ident(input int n);
      send_char(random_letter(), 1'b0);
      for (int i = 1; i < n; i++) begin
         send_char(($urandom_range(0, 2) == 0) ? random_digit() : random_letter(), 1'b0);
      end
   endtask

   task automatic send_number(input int n);
      for (int i = 0; i < n; i++) send_char(random_digit(), 1'b0);
   endtask

   // keywords, plus near misses: capitalized, cut short, or one char too long
   task automatic send_keyword();
      string      w;
      int         variant;
      int         n;
      logic [7:0] ch;
      w = random_keyword();
      variant = $urandom_range(0, 9);
      n = (variant == 1) ? w.len() - 1 : w.len();
      for (int i = 0; i < n; i++) begin
         ch = w[i];
         if (variant == 0 && i == 0) ch = ch - 8'd32;
         send_char(ch, 1'b0);
      end
      if (variant == 2) send_char($urandom_range(0, 1) ? random_digit() : random_letter(), 1'b0);
   endtask

   task automatic send_operator();
      case ($urandom_range(0, 7))
         0:       send_text("+");
         1:       send_text("-");
         2:       send_text("*");
         3:       send_text(";");
         4:       send_text("<");
         5:       send_text("<=");
         6:       send_text("=");
         default: send_text("==");
      endcase
   endtask

   // hold the sender off until every predicted token has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tokens_outstanding != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   initial begin
      int goal;
      int pick;

      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: keyword, <= and ==, number, ;, ident ending on =,
      // = ended by tab, + - *, < ended by newline and by end of input,
      // end of input while idle, number ended by a letter
      send_text("if<=9;Z0===\t+-*<\n<");
      send_eoi();
      send_eoi();
      send_text("7q");
      send_eoi();
      wait_drained();

      // random token streams; no illegal byte yet, it would halt the block
      goal = chars_sent + RANDOM_ITEMS;
      next_pause = chars_sent + $urandom_range(150, 350);
      while (chars_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_keyword();
         end else if (pick < 45) begin
            if ($urandom_range(0, 99) == 0 && long_words < MAX_LONG) begin
               // long enough to saturate the length field
               long_words++;
               send_ident($urandom_range(256, 300));
            end else send_ident($urandom_range(1, 9));
         end else if (pick < 60) begin
            if ($urandom_range(0, 99) == 0 && long_words < MAX_LONG) begin
               long_words++;
               send_number($urandom_range(256, 300));
            end else send_number($urandom_range(1, 6));
         end else if (pick < 85) begin
            send_operator();
         end else if (pick < 95) begin
            send_char(random_space(), 1'b0);
         end else begin
            send_eoi();
         end
         // tokens often butt against each other, so no separator every time
         if ($urandom_range(0, 2) == 0) send_char(random_space(), 1'b0);
         if (chars_sent >= next_pause) begin
            wait_drained();
            next_pause = chars_sent + $urandom_range(150, 350);
         end
      end

      // halting character, sometimes right behind a pending word
      if ($urandom_range(0, 1) == 1) send_ident($urandom_range(1, 4));
      send_char(illegal_char(), 1'b0);

      // halted: nothing below may produce a token, end of input included
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("a", 1'b0);
      send_eoi();
      repeat (HALT_TAIL) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tokens_outstanding != 0) $error("%0d tokens never arrived", tokens_outstanding);
      if (mismatch_count == 0 && tokens_outstanding == 0) begin
         $display("[keyword_token_lexer] OK");
      end else begin
         $display("[keyword_token_lexer] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/klx_pkg.sv
hw/rtl/klx_front.sv
hw/rtl/klx_queue.sv
hw/rtl/klx_back.sv
hw/rtl/keyword_token_lexer.sv
tb/sv/lexer_token_checker.sv
tb/sv/testbench.sv
